### rtl/cse_pkg.sv
// Shared types and character constants for the C string escape encoder.
`timescale 1ns / 1ps
`default_nettype none

package cse_pkg;

  typedef logic [7:0] char_t;

  // How the byte of one item is written out.
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_NONE  = 2'd0;
  localparam kind_t KIND_PLAIN = 2'd1;
  localparam kind_t KIND_NAMED = 2'd2;
  localparam kind_t KIND_HEX   = 2'd3;

  localparam char_t CH_QUOTE  = 8'h22;
  localparam char_t CH_BSLASH = 8'h5C;
  localparam char_t CH_X      = 8'h78;

  // One classified item, ready for expansion into characters.
  typedef struct packed {
    logic  open_q;
    logic  close_q;
    kind_t kind;
    char_t ch;      // plain char, named escape letter, or raw byte for hex
  } desc_t;

endpackage

`default_nettype wire

### rtl/cse_ifs.sv
// Stream interfaces: raw byte items in, escaped characters out.
`timescale 1ns / 1ps
`default_nettype none

interface cse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       begins_string;
  logic       ends_string;

  modport source (output valid, data_byte, has_byte, begins_string, ends_string,
                  input ready);
  modport sink (input valid, data_byte, has_byte, begins_string, ends_string,
                output ready);
endinterface

interface cse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last_of_run;

  modport source (output valid, out_char, last_of_run, input ready);
  modport sink (input valid, out_char, last_of_run, output ready);
endinterface

`default_nettype wire

### rtl/c_string_escape_encoder_unit.sv
// Top level of the C string literal escape encoder.
`timescale 1ns / 1ps
`default_nettype none

// Turns raw string bytes, one per input beat, into the characters of a
// double-quoted C string literal, one character per output beat. An item
// yields 1 character for a plain byte, 2 for a named escape, 4 for a hex
// escape, plus 1 for each quote; items with no byte and no framing flag
// yield none. The output channel at one character per cycle sets the rate
// while the receiver keeps ready high. The front end takes a new item every
// cycle while the QUEUE_DEPTH-entry queue has room, so input stalls only
// once the back end falls that many items behind; the output register lets
// the next character be formed while the previous one waits to be taken.
module c_string_escape_encoder_unit
  import cse_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire       clk,
  input  wire       rst,
  cse_in_if.sink    items,
  cse_out_if.source chars
);

  logic  push;
  logic  pop;
  logic  q_full;
  logic  head_valid;
  desc_t push_desc;
  desc_t head_desc;

  cse_front u_front (
    .clk       (clk),
    .rst       (rst),
    .items     (items),
    .q_full    (q_full),
    .push      (push),
    .push_desc (push_desc)
  );

  cse_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_desc  (push_desc),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_desc  (head_desc)
  );

  cse_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_desc  (head_desc),
    .pop        (pop),
    .chars      (chars)
  );

endmodule

`default_nettype wire

### rtl/cse_front.sv
// Front end: accepts items, classifies the byte and tracks the hex escape flag.
`timescale 1ns / 1ps
`default_nettype none

module cse_front
  import cse_pkg::*;
(
  input  wire   clk,
  input  wire   rst,
  cse_in_if.sink items,
  input  wire   q_full,
  output logic  push,
  output desc_t push_desc
);

  logic  hex_pending;
  logic  hex_pending_next;
  logic  prev_hex;
  logic  is_hex_dig;
  logic  is_print;
  logic  accept;
  char_t named;

  assign items.ready = !q_full;
  assign accept      = items.valid && items.ready;

  always_comb begin
    unique case (items.data_byte)
      8'h22:   named = CH_QUOTE;
      8'h5C:   named = CH_BSLASH;
      8'h07:   named = 8'h61;  // a
      8'h08:   named = 8'h62;  // b
      8'h0C:   named = 8'h66;  // f
      8'h0A:   named = 8'h6E;  // n
      8'h0D:   named = 8'h72;  // r
      8'h09:   named = 8'h74;  // t
      8'h0B:   named = 8'h76;  // v
      default: named = 8'h00;
    endcase
  end

  assign prev_hex   = hex_pending && !items.begins_string;
  assign is_print   = (items.data_byte >= 8'h20) && (items.data_byte <= 8'h7E);
  assign is_hex_dig = ((items.data_byte >= 8'h30) && (items.data_byte <= 8'h39)) ||
                      ((items.data_byte >= 8'h61) && (items.data_byte <= 8'h66)) ||
                      ((items.data_byte >= 8'h41) && (items.data_byte <= 8'h46));

  always_comb begin
    push_desc.open_q  = items.begins_string;
    push_desc.close_q = items.ends_string;
    push_desc.ch      = items.data_byte;
    hex_pending_next  = prev_hex;
    if (!items.has_byte) begin
      push_desc.kind = KIND_NONE;
    end else if (named != 8'h00) begin
      push_desc.kind   = KIND_NAMED;
      push_desc.ch     = named;
      hex_pending_next = 1'b0;
    end else if (is_print && !(prev_hex && is_hex_dig)) begin
      push_desc.kind   = KIND_PLAIN;
      hex_pending_next = 1'b0;
    end else begin
      push_desc.kind   = KIND_HEX;
      hex_pending_next = 1'b1;
    end
    if (items.ends_string) begin
      hex_pending_next = 1'b0;
    end
  end

  // Items that cause no characters are taken but never queued.
  assign push = accept && (items.has_byte || items.begins_string || items.ends_string);

  always_ff @(posedge clk) begin
    if (rst) begin
      hex_pending <= 1'b0;
    end else if (accept) begin
      hex_pending <= hex_pending_next;
    end
  end

endmodule

`default_nettype wire

### rtl/cse_queue.sv
// Short show-ahead queue of classified items between front and back.
`timescale 1ns / 1ps
`default_nettype none

module cse_queue
  import cse_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  wire   clk,
  input  wire   rst,
  input  wire   push,
  input  desc_t push_desc,
  input  wire   pop,
  output logic  full,
  output logic  head_valid,
  output desc_t head_desc
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  desc_t         mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full       = (count == FULL_CNT);
  assign head_valid = (count != '0);
  assign head_desc  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/cse_back.sv
// Back end: expands the queue head into characters, one per beat.
`timescale 1ns / 1ps
`default_nettype none

module cse_back
  import cse_pkg::*;
(
  input  wire     clk,
  input  wire     rst,
  input  wire     head_valid,
  input  desc_t   head_desc,
  output logic    pop,
  cse_out_if.source chars
);

  logic [2:0] pos;
  logic [2:0] body_len;
  logic [2:0] run_len;
  logic [2:0] off;
  logic       load;
  logic       is_last;
  char_t      body_ch;
  char_t      cur_ch;

  function automatic char_t hex_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      hex_char = 8'h30 + {4'd0, nib};
    end else begin
      hex_char = 8'h57 + {4'd0, nib};  // 10 maps to 'a'
    end
  endfunction

  always_comb begin
    unique case (head_desc.kind)
      KIND_PLAIN: body_len = 3'd1;
      KIND_NAMED: body_len = 3'd2;
      KIND_HEX:   body_len = 3'd4;
      default:    body_len = 3'd0;
    endcase
  end

  assign run_len = {2'b00, head_desc.open_q} + body_len + {2'b00, head_desc.close_q};
  assign off     = pos - {2'b00, head_desc.open_q};
  assign is_last = (pos == run_len - 3'd1);

  always_comb begin
    unique case (head_desc.kind)
      KIND_PLAIN: body_ch = head_desc.ch;
      KIND_NAMED: body_ch = (off == 3'd0) ? CH_BSLASH : head_desc.ch;
      KIND_HEX: begin
        unique case (off[1:0])
          2'd0:    body_ch = CH_BSLASH;
          2'd1:    body_ch = CH_X;
          2'd2:    body_ch = hex_char(head_desc.ch[7:4]);
          default: body_ch = hex_char(head_desc.ch[3:0]);
        endcase
      end
      default: body_ch = CH_QUOTE;
    endcase
  end

  always_comb begin
    if (head_desc.open_q && (pos == 3'd0)) begin
      cur_ch = CH_QUOTE;
    end else if (off < body_len) begin
      cur_ch = body_ch;
    end else begin
      cur_ch = CH_QUOTE;
    end
  end

  assign load = head_valid && (!chars.valid || chars.ready);
  assign pop  = load && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      chars.valid <= 1'b0;
      pos         <= '0;
    end else begin
      if (load) begin
        chars.valid <= 1'b1;
        pos         <= is_last ? 3'd0 : pos + 3'd1;
      end else if (chars.ready) begin
        chars.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      chars.out_char    <= cur_ch;
      chars.last_of_run <= is_last;
    end
  end

endmodule

`default_nettype wire

### test/c_string_escape_encoder_unit_tb.sv
// Testbench for the C string escape encoder: directed table, then random strings.
`timescale 1ns / 1ps

module c_string_escape_encoder_unit_tb;
  import cse_pkg::*;

  localparam int DIR_N = 25;
  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_CYCLES = 16;

  localparam char_t CH_NUL   = 8'h00;
  localparam char_t CH_BEL   = 8'h07;
  localparam char_t CH_BS    = 8'h08;
  localparam char_t CH_TAB   = 8'h09;
  localparam char_t CH_LF    = 8'h0A;
  localparam char_t CH_VT    = 8'h0B;
  localparam char_t CH_FF    = 8'h0C;
  localparam char_t CH_CR    = 8'h0D;
  localparam char_t CH_SPACE = 8'h20;
  localparam char_t CH_TILDE = 8'h7E;
  localparam char_t CH_DEL   = 8'h7F;
  localparam char_t CH_ZERO  = "0";
  localparam char_t CH_NINE  = "9";
  localparam char_t CH_LOW_A = "a";
  localparam char_t CH_LOW_F = "f";
  localparam char_t CH_UP_A  = "A";
  localparam char_t CH_UP_F  = "F";

  typedef struct {
    char_t       data;
    logic        has;
    logic        opens;
    logic        closes;
    int          typed_n;   // 0: check against the predictor
    logic [47:0] typed;     // typed-in literal, right-justified
  } item_row_t;

  typedef struct packed {
    char_t ch;
    logic  last;
  } lit_char_t;

  logic clk;
  logic rst;

  cse_in_if  items_bus ();
  cse_out_if chars_bus ();

  c_string_escape_encoder_unit u_dut (
    .clk  (clk),
    .rst  (rst),
    .items(items_bus),
    .chars(chars_bus)
  );

  item_row_t dir_tab [DIR_N] = '{
    '{8'h00, 1'b1, 1'b1, 1'b0, 5, "\"\\x00"},
    '{8'h41, 1'b1, 1'b0, 1'b0, 4, "\\x41"},
    '{8'h67, 1'b1, 1'b0, 1'b0, 0, 48'd0},
    '{8'hFF, 1'b1, 1'b0, 1'b0, 4, "\\xff"},
    '{8'h30, 1'b1, 1'b0, 1'b0, 4, "\\x30"},
    '{8'h5A, 1'b0, 1'b0, 1'b1, 1, "\""},
    '{8'h00, 1'b0, 1'b1, 1'b1, 2, "\"\""},
    '{8'hA5, 1'b0, 1'b0, 1'b0, 0, 48'd0},
    '{8'h22, 1'b1, 1'b1, 1'b0, 3, "\"\\\""},
    '{8'h5C, 1'b1, 1'b0, 1'b0, 2, "\\\\"},
    '{8'h07, 1'b1, 1'b0, 1'b0, 2, "\\a"},
    '{8'h08, 1'b1, 1'b0, 1'b0, 2, "\\b"},
    '{8'h0C, 1'b1, 1'b0, 1'b0, 2, "\\f"},
    '{8'h0A, 1'b1, 1'b0, 1'b0, 2, "\\n"},
    '{8'h0D, 1'b1, 1'b0, 1'b0, 2, "\\r"},
    '{8'h09, 1'b1, 1'b0, 1'b0, 2, "\\t"},
    '{8'h0B, 1'b1, 1'b0, 1'b0, 2, "\\v"},
    '{8'h20, 1'b1, 1'b0, 1'b0, 1, " "},
    '{8'h7E, 1'b1, 1'b0, 1'b0, 1, "~"},
    '{8'h7F, 1'b1, 1'b0, 1'b0, 4, "\\x7f"},
    '{8'h1F, 1'b1, 1'b0, 1'b0, 4, "\\x1f"},
    '{8'h80, 1'b1, 1'b1, 1'b1, 6, "\"\\x80\""},
    '{8'h66, 1'b1, 1'b0, 1'b0, 0, 48'd0},
    '{8'h01, 1'b1, 1'b1, 1'b0, 5, "\"\\x01"},
    '{8'h61, 1'b1, 1'b1, 1'b0, 0, 48'd0}
  };

  char_t     named_set [9] = '{CH_QUOTE, CH_BSLASH, CH_BEL, CH_BS, CH_FF, CH_LF, CH_CR,
                               CH_TAB, CH_VT};
  item_row_t cur_row;
  logic      hex_pending;
  char_t     escaped_q [$];
  lit_char_t literal_q [$];
  int        error_count;
  int        quiet_cycles;
  int        send_idle_pct;
  int        recv_idle_pct;
  bit        hold_request;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic char_t hex_char(input logic [3:0] nib);
    return (nib < 4'd10) ? char_t'(CH_ZERO + nib) : char_t'(CH_LOW_A + (nib - 4'd10));
  endfunction

  // Characters caused by one item, in order; updates the hex-escape flag.
  function automatic void escape_item(input item_row_t r);
    char_t named;
    logic  is_hexd;
    escaped_q.delete();
    if (r.opens) begin
      escaped_q.push_back(CH_QUOTE);
      hex_pending = 1'b0;
    end
    if (r.has) begin
      case (r.data)
        CH_QUOTE:  named = CH_QUOTE;
        CH_BSLASH: named = CH_BSLASH;
        CH_BEL:    named = "a";
        CH_BS:     named = "b";
        CH_FF:     named = "f";
        CH_LF:     named = "n";
        CH_CR:     named = "r";
        CH_TAB:    named = "t";
        CH_VT:     named = "v";
        default:   named = CH_NUL;
      endcase
      is_hexd = (r.data >= CH_ZERO && r.data <= CH_NINE) ||
                (r.data >= CH_LOW_A && r.data <= CH_LOW_F) ||
                (r.data >= CH_UP_A && r.data <= CH_UP_F);
      if (named != CH_NUL) begin
        escaped_q.push_back(CH_BSLASH);
        escaped_q.push_back(named);
        hex_pending = 1'b0;
      end else if (r.data >= CH_SPACE && r.data <= CH_TILDE && !(hex_pending && is_hexd)) begin
        escaped_q.push_back(r.data);
        hex_pending = 1'b0;
      end else begin
        escaped_q.push_back(CH_BSLASH);
        escaped_q.push_back(CH_X);
        escaped_q.push_back(hex_char(r.data[7:4]));
        escaped_q.push_back(hex_char(r.data[3:0]));
        hex_pending = 1'b1;
      end
    end
    if (r.closes) begin
      escaped_q.push_back(CH_QUOTE);
      hex_pending = 1'b0;
    end
  endfunction

  // Biased toward bytes that exercise escapes and the hex-digit follow-on rule.
  function automatic char_t pick_byte();
    case ($urandom_range(5))
      0: return char_t'($urandom_range(255));
      1: return char_t'($urandom_range(31));
      2: return char_t'($urandom_range(255, 127));
      3: begin
        case ($urandom_range(2))
          0: return char_t'(CH_ZERO + $urandom_range(9));
          1: return char_t'(CH_LOW_A + $urandom_range(5));
          default: return char_t'(CH_UP_A + $urandom_range(5));
        endcase
      end
      4: return named_set[$urandom_range(8)];
      default: return char_t'($urandom_range(126, 32));
    endcase
  endfunction

  // Scoreboard and watchdog
  always @(posedge clk) begin : scoreboard
    lit_char_t want;
    int        n;
    bit        moved;
    moved = 1'b0;
    if (!rst) begin
      if (items_bus.valid && items_bus.ready) begin
        moved = 1'b1;
        escape_item(cur_row);
        if (cur_row.typed_n != 0) begin
          escaped_q.delete();
          for (int k = 0; k < cur_row.typed_n; k++)
            escaped_q.push_back(cur_row.typed[8 * (cur_row.typed_n - 1 - k) +: 8]);
        end
        n = escaped_q.size();
        for (int k = 0; k < n; k++)
          literal_q.push_back('{ch: escaped_q[k], last: (k == n - 1)});
      end
      if (chars_bus.valid && chars_bus.ready) begin
        moved = 1'b1;
        if (literal_q.size() == 0) begin
          $error("out_char: no beat expected, got %h", chars_bus.out_char);
          error_count++;
        end else begin
          want = literal_q.pop_front();
          if (chars_bus.out_char !== want.ch) begin
            $error("out_char: expected %h, got %h", want.ch, chars_bus.out_char);
            error_count++;
          end
          if (chars_bus.last_of_run !== want.last) begin
            $error("last_of_run: expected %b, got %b", want.last, chars_bus.last_of_run);
            error_count++;
          end
        end
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL c_string_escape_encoder_unit");
      $finish;
    end
  end

  // Receiver: random back-pressure, plus a long hold-off on request
  always begin
    @(negedge clk);
    if (hold_request) begin
      chars_bus.ready <= 1'b0;
      repeat (HOLD_CYCLES) @(negedge clk);
      hold_request = 1'b0;
    end else begin
      chars_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat.
  task automatic send_item(input item_row_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      items_bus.valid <= 1'b0;
      @(negedge clk);
    end
    cur_row = r;
    items_bus.valid         <= 1'b1;
    items_bus.data_byte     <= r.data;
    items_bus.has_byte      <= r.has;
    items_bus.begins_string <= r.opens;
    items_bus.ends_string   <= r.closes;
    do @(posedge clk); while (!items_bus.ready);
    @(negedge clk);
  endtask

  // Mostly framed strings with random content; the rest is loose noise.
  task automatic send_strings(input int n_items);
    item_row_t r;
    int        sent;
    int        len;
    sent = 0;
    r.typed_n = 0;
    r.typed = '0;
    while (sent < n_items) begin
      if ($urandom_range(9) < 8) begin
        len = $urandom_range(8);
        if (len == 0) begin
          r.data = char_t'($urandom_range(255));
          r.has = 1'b0;
          r.opens = 1'b1;
          r.closes = 1'b1;
          send_item(r);
          sent++;
        end
        for (int k = 0; k < len; k++) begin
          r.data = pick_byte();
          r.has = 1'b1;
          r.opens = (k == 0);
          r.closes = (k == len - 1);
          send_item(r);
          sent++;
        end
      end else begin
        r.data = char_t'($urandom_range(255));
        r.has = $urandom_range(1);
        r.opens = $urandom_range(1);
        r.closes = $urandom_range(1);
        send_item(r);
        if (r.has || r.opens || r.closes)
          sent++;
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    items_bus.valid = 1'b0;
    items_bus.data_byte = '0;
    items_bus.has_byte = 1'b0;
    items_bus.begins_string = 1'b0;
    items_bus.ends_string = 1'b0;
    chars_bus.ready = 1'b0;
    hex_pending = 1'b0;
    error_count = 0;
    quiet_cycles = 0;
    send_idle_pct = 33;
    recv_idle_pct = 84;
    hold_request = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < DIR_N; i++)
      send_item(dir_tab[i]);

    send_strings(135);
    send_idle_pct = 84;
    recv_idle_pct = 33;
    send_strings(135);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // sender keeps offering beats while the receiver holds off
    hold_request = 1'b1;
    send_strings(130);
    items_bus.valid <= 1'b0;

    while (literal_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS c_string_escape_encoder_unit");
    end else begin
      $display("FAIL c_string_escape_encoder_unit");
    end
    $finish;
  end

endmodule
